// ===== src/vcsw_pkg.sv =====
// Shared types, constants and lookup tables for the command-to-synthesizer block.
`timescale 1ns / 1ps

package vcsw_pkg;

    // Work handed from the command front end to the frame sequencer
    typedef enum logic [2:0] {
        ACT_TUNE,
        ACT_PLOW,
        ACT_PON,
        ACT_STAT,
        ACT_TICK
    } act_op_t;

    typedef struct packed {
        act_op_t     op;
        logic [12:0] freq;
    } action_t;

    // Result sequences run by the back end
    typedef enum logic [2:0] {
        SEQ_TUNE,
        SEQ_PLOW,
        SEQ_PON,
        SEQ_STAT,
        SEQ_AMP
    } seq_t;

    typedef enum logic [1:0] {
        CFG_SETTLE_TICKS,
        CFG_PA_FULL_WORD,
        CFG_PA_LOW_WORD,
        CFG_VCO_CONTROL_WORD
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] settle_ticks;
        logic [19:0] pa_full_word;
        logic [19:0] pa_low_word;
        logic [19:0] vco_control_word;
    } cfg_t;

    localparam logic [15:0] SETTLE_TICKS_RST     = 16'd500;
    localparam logic [19:0] PA_FULL_WORD_RST     = 20'h04FBD;
    localparam logic [19:0] PA_LOW_WORD_RST      = 20'h00F3F;
    localparam logic [19:0] VCO_CONTROL_WORD_RST = 20'h0FFD7;

    localparam logic [15:0] FREQ_MIN   = 16'd5645;
    localparam logic [15:0] FREQ_MAX   = 16'd5945;
    localparam logic [12:0] FREQ_RESET = 13'd5809;

    // MHz to synthesizer counts: f * 1000 / 40
    localparam int FREQ_SCALE = 1000 / 40;

    localparam logic [3:0] ADDR_SYN_B = 4'd1;
    localparam logic [3:0] ADDR_VCO   = 4'd3;
    localparam logic [3:0] ADDR_PA    = 4'd7;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_C  = 8'h43;
    localparam logic [7:0] CH_F  = 8'h46;
    localparam logic [7:0] CH_P  = 8'h50;
    localparam logic [7:0] CH_S  = 8'h53;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    function automatic logic [12:0] chan_base_mhz(input logic [2:0] band);
        logic [12:0] r;
        unique case (band)
            3'd0:    r = 13'd5658;
            3'd1:    r = 13'd5865;
            3'd2:    r = 13'd5733;
            3'd3:    r = 13'd5705;
            3'd4:    r = 13'd5740;
            3'd5:    r = 13'd5705;
            3'd6:    r = 13'd5658;
            default: r = 13'd5809;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] chan_gap_mhz(input logic [2:0] band);
        logic [5:0] r;
        unique case (band)
            3'd0:    r = 6'd37;
            3'd6:    r = 6'd37;
            3'd7:    r = 6'd7;
            default: r = 6'd5;
        endcase
        return r;
    endfunction

endpackage

// ===== src/vcsw_front.sv =====
// Front end: collects the command line, decodes commands and ticks into queued work.
`timescale 1ns / 1ps

module vcsw_front #(
    parameter int LINE_DEPTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // rx_byte
    input  logic              s_tuser,   // operation
    input  logic              q_full,
    output logic              q_push,
    output vcsw_pkg::action_t q_data
);

    localparam int CW = $clog2(LINE_DEPTH);

    logic [CW-1:0] byte_count_reg, byte_count_next;
    logic [7:0]    cmd_bytes_reg [3];

    logic          accept;
    logic          is_term;
    logic          have2, have3;
    logic [15:0]   f_word;
    logic [2:0]    band, chan;
    logic [13:0]   c_sum;
    logic [12:0]   c_freq;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign is_term  = (s_tdata == vcsw_pkg::CH_LF) || (s_tdata == vcsw_pkg::CH_CR);
    assign have2    = byte_count_reg >= CW'(2);
    assign have3    = byte_count_reg >= CW'(3);

    // Channel lookup: band and channel above 7 fall back to 0, result clamped
    always_comb begin
        f_word = {cmd_bytes_reg[2], cmd_bytes_reg[1]};
        band   = (cmd_bytes_reg[1][7:3] == 5'd0) ? cmd_bytes_reg[1][2:0] : 3'd0;
        chan   = (cmd_bytes_reg[2][7:3] == 5'd0) ? cmd_bytes_reg[2][2:0] : 3'd0;
        c_sum  = 14'(vcsw_pkg::chan_base_mhz(band))
               + 14'(9'(chan) * 9'(vcsw_pkg::chan_gap_mhz(band)));
        if ({2'b00, c_sum} < vcsw_pkg::FREQ_MIN) begin
            c_freq = vcsw_pkg::FREQ_MIN[12:0];
        end else if ({2'b00, c_sum} > vcsw_pkg::FREQ_MAX) begin
            c_freq = vcsw_pkg::FREQ_MAX[12:0];
        end else begin
            c_freq = c_sum[12:0];
        end
    end

    always_comb begin
        q_push      = 1'b0;
        q_data.op   = vcsw_pkg::ACT_TICK;
        q_data.freq = '0;
        if (accept) begin
            if (s_tuser) begin
                q_push = 1'b1;
            end else if (is_term && (byte_count_reg != '0)) begin
                unique case (cmd_bytes_reg[0])
                    vcsw_pkg::CH_F: begin
                        if (have3 && (f_word >= vcsw_pkg::FREQ_MIN)
                                  && (f_word <= vcsw_pkg::FREQ_MAX)) begin
                            q_push      = 1'b1;
                            q_data.op   = vcsw_pkg::ACT_TUNE;
                            q_data.freq = f_word[12:0];
                        end
                    end
                    vcsw_pkg::CH_C: begin
                        if (have3) begin
                            q_push      = 1'b1;
                            q_data.op   = vcsw_pkg::ACT_TUNE;
                            q_data.freq = c_freq;
                        end
                    end
                    vcsw_pkg::CH_P: begin
                        if (have2) begin
                            q_push    = 1'b1;
                            q_data.op = (cmd_bytes_reg[1] == 8'd0) ? vcsw_pkg::ACT_PLOW
                                                                   : vcsw_pkg::ACT_PON;
                        end
                    end
                    vcsw_pkg::CH_S: begin
                        q_push    = 1'b1;
                        q_data.op = vcsw_pkg::ACT_STAT;
                    end
                    default: begin
                        q_push = 1'b0;
                    end
                endcase
            end
        end
    end

    // Overlong lines wrap to empty and are dropped
    always_comb begin
        byte_count_next = byte_count_reg;
        if (accept && !s_tuser) begin
            if (is_term) begin
                byte_count_next = '0;
            end else if (byte_count_reg < CW'(LINE_DEPTH - 1)) begin
                byte_count_next = byte_count_reg + CW'(1);
            end else begin
                byte_count_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
        end else begin
            byte_count_reg <= byte_count_next;
        end
    end

    // Keep only the first three bytes of a line, terminator included
    always_ff @(posedge aclk) begin
        if (accept && !s_tuser && have3 == 1'b0) begin
            cmd_bytes_reg[byte_count_reg[1:0]] <= s_tdata;
        end
    end

endmodule

// ===== src/vcsw_fifo.sv =====
// Small work queue between the command front end and the frame sequencer.
`timescale 1ns / 1ps

module vcsw_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  vcsw_pkg::action_t din,
    output logic              full,
    input  logic              pop,
    output vcsw_pkg::action_t dout,
    output logic              empty
);

    localparam int AW = vcsw_pkg::Q_AW;

    vcsw_pkg::action_t entries_reg [vcsw_pkg::Q_DEPTH];
    logic [AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]       count_reg, count_next;

    assign full  = count_reg == (AW + 1)'(vcsw_pkg::Q_DEPTH);
    assign empty = count_reg == '0;
    assign dout  = entries_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (AW + 1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (AW + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== src/vcsw_back.sv =====
// Back end: runs queued work, keeps tuning and settle timer state, emits result words.
`timescale 1ns / 1ps

module vcsw_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  vcsw_pkg::cfg_t    cfg,
    input  logic              q_empty,
    input  vcsw_pkg::action_t q_data,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,   // spi_frame[24:0], reply_byte[32:25], zero pad
    output logic              m_tuser,   // kind
    output logic              m_tlast    // last
);

    logic           cur_valid_reg;
    vcsw_pkg::seq_t cur_seq_reg;
    logic [1:0]     cur_step_reg;
    logic [19:0]    cur_data_reg;
    logic [12:0]    current_freq_reg;
    logic           timer_armed_reg;
    logic [15:0]    timer_left_reg;

    logic           m_tvalid_reg;
    logic [39:0]    m_tdata_reg, m_tdata_next;
    logic           m_tuser_reg, m_tuser_next;
    logic           m_tlast_reg;

    logic           out_free, emit, is_last, done;
    logic [1:0]     last_step;
    logic [17:0]    v;
    logic [19:0]    syn_data;
    logic [15:0]    t_dec;
    logic           load_valid;
    vcsw_pkg::seq_t load_seq;
    logic [19:0]    load_data;
    logic [3:0]     r_addr;
    logic [19:0]    r_data;
    logic [7:0]     r_reply;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assign last_step = ((cur_seq_reg == vcsw_pkg::SEQ_PON) ||
                        (cur_seq_reg == vcsw_pkg::SEQ_STAT)) ? 2'd2 : 2'd1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit      = cur_valid_reg && out_free;
    assign is_last   = cur_step_reg == last_step;
    assign done      = emit && is_last;
    // Pull the next job when idle or as the current one issues its final word
    assign q_pop     = !q_empty && (!cur_valid_reg || done);

    // Synthesizer B word: A = v mod 64 in bits 5:0, N = v / 64 from bit 7
    assign v        = 18'(q_data.freq) * 18'(vcsw_pkg::FREQ_SCALE);
    assign syn_data = {1'b0, v[17:6], 1'b0, v[5:0]};
    assign t_dec    = (timer_left_reg != 16'd0) ? timer_left_reg - 16'd1 : timer_left_reg;

    always_comb begin
        load_valid = 1'b1;
        load_seq   = vcsw_pkg::SEQ_TUNE;
        load_data  = '0;
        unique case (q_data.op)
            vcsw_pkg::ACT_TUNE: begin
                load_data = syn_data;
            end
            vcsw_pkg::ACT_PLOW: begin
                load_seq = vcsw_pkg::SEQ_PLOW;
            end
            vcsw_pkg::ACT_PON: begin
                load_seq = vcsw_pkg::SEQ_PON;
            end
            vcsw_pkg::ACT_STAT: begin
                load_seq  = vcsw_pkg::SEQ_STAT;
                load_data = 20'(current_freq_reg);
            end
            vcsw_pkg::ACT_TICK: begin
                load_seq   = vcsw_pkg::SEQ_AMP;
                load_valid = timer_armed_reg && (t_dec == 16'd0);
            end
            default: begin
                load_valid = 1'b0;
            end
        endcase
    end

    // Word for the current sequence step
    always_comb begin
        r_addr  = vcsw_pkg::ADDR_PA;
        r_data  = '0;
        r_reply = '0;
        m_tuser_next = 1'b0;
        unique case (cur_seq_reg)
            vcsw_pkg::SEQ_TUNE: begin
                if (cur_step_reg == 2'd0) begin
                    r_addr = vcsw_pkg::ADDR_SYN_B;
                    r_data = cur_data_reg;
                end else begin
                    r_addr = vcsw_pkg::ADDR_VCO;
                    r_data = cfg.vco_control_word;
                end
            end
            vcsw_pkg::SEQ_PLOW: begin
                if (cur_step_reg != 2'd0) begin
                    r_data = cfg.pa_low_word;
                end
            end
            vcsw_pkg::SEQ_PON: begin
                if (cur_step_reg == 2'd2) begin
                    r_data = cfg.pa_full_word;
                end
            end
            vcsw_pkg::SEQ_AMP: begin
                if (cur_step_reg != 2'd0) begin
                    r_data = cfg.pa_full_word;
                end
            end
            vcsw_pkg::SEQ_STAT: begin
                m_tuser_next = 1'b1;
                if (cur_step_reg == 2'd0) begin
                    r_reply = vcsw_pkg::CH_F;
                end else if (cur_step_reg == 2'd1) begin
                    r_reply = cur_data_reg[7:0];
                end else begin
                    r_reply = {3'b000, cur_data_reg[12:8]};
                end
            end
            default: begin
                r_data = '0;
            end
        endcase
        if (m_tuser_next) begin
            m_tdata_next = {7'd0, r_reply, 25'd0};
        end else begin
            m_tdata_next = {7'd0, 8'd0, r_data, 1'b1, r_addr};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg    <= 1'b0;
            current_freq_reg <= vcsw_pkg::FREQ_RESET;
            timer_armed_reg  <= 1'b0;
            timer_left_reg   <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (q_pop) begin
                cur_valid_reg <= load_valid;
                if (q_data.op == vcsw_pkg::ACT_TUNE) begin
                    current_freq_reg <= q_data.freq;
                    timer_left_reg   <= cfg.settle_ticks;
                    timer_armed_reg  <= 1'b1;
                end else if ((q_data.op == vcsw_pkg::ACT_TICK) && timer_armed_reg) begin
                    timer_left_reg <= t_dec;
                    if (t_dec == 16'd0) begin
                        timer_armed_reg <= 1'b0;
                    end
                end
            end else if (done) begin
                cur_valid_reg <= 1'b0;
            end
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_seq_reg  <= load_seq;
            cur_step_reg <= 2'd0;
            cur_data_reg <= load_data;
        end else if (emit) begin
            cur_step_reg <= cur_step_reg + 2'd1;
        end
        if (emit) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
            m_tlast_reg <= is_last;
        end
    end

endmodule

// ===== src/vtx_command_to_synth_writes.sv =====
// Top level: configuration registers and the front end, queue and sequencer.
`timescale 1ns / 1ps

// Command front end for a 5.8 GHz video transmitter synthesizer.
// Input stream: s_tuser = 0 carries a received UART byte in s_tdata, s_tuser = 1 is a
// millisecond tick. Output stream: m_tuser = 0 carries a 25-bit synthesizer write frame
// in m_tdata[24:0], m_tuser = 1 a reply byte in m_tdata[32:25]; m_tlast marks the final
// word caused by one input word. An input word causes zero to three output words.
// Configuration: cfg_addr selects settle_ticks (0), pa_full_word (1), pa_low_word (2)
// or vco_control_word (3); cfg_ready is always high. Write only while idle.
// Path: an accepted input word passes through the work queue, the sequencer's current-job
// register and the output register before its first output word shows on m_tvalid. The
// sequencer issues one word per cycle while the receiver takes them; three words at most.
// The front end takes one word per cycle while its four-entry work queue has room.
// Reset (aresetn low, synchronous) empties the line and queue, disarms the settle timer,
// restores the registers and sets the current frequency to 5809 MHz.
// When the receiver stalls, the output register holds its word, the sequencer and then
// the queue fill, and s_tready falls once the queue is full.
module vtx_command_to_synth_writes #(
    parameter int LINE_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // rx_byte
    input  logic        s_tuser,    // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // spi_frame[24:0], reply_byte[32:25], zero pad
    output logic        m_tuser,    // kind
    output logic        m_tlast,    // last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [19:0] cfg_data
);

    vcsw_pkg::cfg_t    cfg_reg;
    logic              q_push, q_pop, q_full, q_empty;
    vcsw_pkg::action_t q_in, q_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.settle_ticks     <= vcsw_pkg::SETTLE_TICKS_RST;
            cfg_reg.pa_full_word     <= vcsw_pkg::PA_FULL_WORD_RST;
            cfg_reg.pa_low_word      <= vcsw_pkg::PA_LOW_WORD_RST;
            cfg_reg.vco_control_word <= vcsw_pkg::VCO_CONTROL_WORD_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (vcsw_pkg::cfg_idx_t'(cfg_addr))
                vcsw_pkg::CFG_SETTLE_TICKS:     cfg_reg.settle_ticks     <= cfg_data[15:0];
                vcsw_pkg::CFG_PA_FULL_WORD:     cfg_reg.pa_full_word     <= cfg_data;
                vcsw_pkg::CFG_PA_LOW_WORD:      cfg_reg.pa_low_word      <= cfg_data;
                vcsw_pkg::CFG_VCO_CONTROL_WORD: cfg_reg.vco_control_word <= cfg_data;
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    vcsw_front #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    vcsw_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_in),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_out),
        .empty   (q_empty)
    );

    vcsw_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== bench/vtx_command_to_synth_writes_tb.sv =====
// Self-checking bench for the command-line to synthesizer-write block.
`timescale 1ns / 1ps

module vtx_command_to_synth_writes_tb;

    localparam int        LINE_DEPTH  = 32;
    localparam int        CYCLE_LIMIT = 400000;
    localparam logic      OP_RX       = 1'b0;
    localparam logic      OP_TICK     = 1'b1;
    localparam logic [7:0] CH_UNKNOWN = 8'h58;

    typedef struct packed {
        logic        kind;
        logic [24:0] frame;
        logic [7:0]  reply;
        logic        last;
    } synth_word_t;

    typedef struct packed {
        logic       op;
        logic [7:0] b;
        logic       typed;
        logic [1:0] n;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // rx_byte
    logic        s_tuser;     // operation
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;     // spi_frame[24:0], reply_byte[32:25], zero pad
    logic        m_tuser;     // kind
    logic        m_tlast;     // last
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_addr;
    logic [19:0] cfg_data;

    // Shadow state of the command line, tuning, settle timer and config registers
    logic [7:0]  line_buf [3] = '{8'h00, 8'h00, 8'h00};
    logic [4:0]  line_len     = '0;
    logic [12:0] freq_now     = vcsw_pkg::FREQ_RESET;
    logic        amp_armed    = 1'b0;
    logic [15:0] amp_wait     = '0;
    logic [15:0] reg_settle   = vcsw_pkg::SETTLE_TICKS_RST;
    logic [19:0] reg_pa_full  = vcsw_pkg::PA_FULL_WORD_RST;
    logic [19:0] reg_pa_low   = vcsw_pkg::PA_LOW_WORD_RST;
    logic [19:0] reg_vco      = vcsw_pkg::VCO_CONTROL_WORD_RST;

    int band_mhz [8] = '{5658, 5865, 5733, 5705, 5740, 5705, 5658, 5809};
    int band_gap [8] = '{37, 5, 5, 5, 5, 5, 37, 7};

    synth_word_t step_words  [$];
    synth_word_t due_words   [$];
    synth_word_t typed_words [$];
    dir_row_t    dir_rows    [26];

    int sent_items  = 0;
    int mismatches  = 0;
    int cycle_count = 0;
    bit calm        = 1'b0;

    vtx_command_to_synth_writes #(
        .LINE_DEPTH(LINE_DEPTH)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic synth_word_t frame_word(input logic [3:0] addr,
                                               input logic [19:0] data);
        synth_word_t w;
        w = '0;
        w.frame = {data, 1'b1, addr};
        return w;
    endfunction

    function automatic synth_word_t reply_word(input logic [7:0] b);
        synth_word_t w;
        w = '0;
        w.kind = 1'b1;
        w.reply = b;
        return w;
    endfunction

    function automatic void amp_on();
        step_words.push_back(frame_word(vcsw_pkg::ADDR_PA, 20'h0));
        step_words.push_back(frame_word(vcsw_pkg::ADDR_PA, reg_pa_full));
    endfunction

    function automatic void tune_to(input logic [15:0] f_in);
        logic [15:0] f;
        int          v;
        f = f_in;
        if (f < vcsw_pkg::FREQ_MIN) f = vcsw_pkg::FREQ_MIN;
        if (f > vcsw_pkg::FREQ_MAX) f = vcsw_pkg::FREQ_MAX;
        v = f * 1000 / 40;
        step_words.push_back(frame_word(vcsw_pkg::ADDR_SYN_B,
                                        20'((v % 64) | ((v / 64) << 7))));
        step_words.push_back(frame_word(vcsw_pkg::ADDR_VCO, reg_vco));
        freq_now  = f[12:0];
        amp_wait  = reg_settle;
        amp_armed = 1'b1;
    endfunction

    function automatic void run_line(input logic [4:0] len);
        logic [7:0]  band;
        logic [7:0]  chan;
        logic [15:0] f;
        unique case (line_buf[0])
            vcsw_pkg::CH_F: begin
                f = {line_buf[2], line_buf[1]};
                if (len >= 3 && f >= vcsw_pkg::FREQ_MIN && f <= vcsw_pkg::FREQ_MAX)
                    tune_to(f);
            end
            vcsw_pkg::CH_C: begin
                if (len >= 3) begin
                    band = line_buf[1];
                    chan = line_buf[2];
                    // out-of-table band or channel falls back to entry zero
                    if (band >= 8) band = 8'd0;
                    if (chan >= 8) chan = 8'd0;
                    f = 16'(band_mhz[band[2:0]] + int'(chan) * band_gap[band[2:0]]);
                    tune_to(f);
                end
            end
            vcsw_pkg::CH_P: begin
                if (len >= 2) begin
                    step_words.push_back(frame_word(vcsw_pkg::ADDR_PA, 20'h0));
                    if (line_buf[1] == 8'h00)
                        step_words.push_back(frame_word(vcsw_pkg::ADDR_PA, reg_pa_low));
                    else amp_on();
                end
            end
            vcsw_pkg::CH_S: begin
                step_words.push_back(reply_word(vcsw_pkg::CH_F));
                step_words.push_back(reply_word(freq_now[7:0]));
                step_words.push_back(reply_word({3'b000, freq_now[12:8]}));
            end
            default: ;
        endcase
    endfunction

    function automatic void decode_rx_word(input logic op, input logic [7:0] b);
        step_words.delete();
        if (op == OP_TICK) begin
            if (amp_armed) begin
                if (amp_wait != 0) amp_wait--;
                if (amp_wait == 0) begin
                    amp_on();
                    amp_armed = 1'b0;
                end
            end
        end else begin
            if (line_len < 3) line_buf[line_len] = b;
            if (b == vcsw_pkg::CH_LF || b == vcsw_pkg::CH_CR) begin
                if (line_len > 0) run_line(line_len);
                line_len = '0;
            end else if (line_len < LINE_DEPTH - 1) begin
                line_len++;
            end else begin
                // overflow: drop the line
                line_len = '0;
            end
        end
        if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
    endfunction

    function automatic int pause_len();
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == vcsw_pkg::CH_LF || b == vcsw_pkg::CH_CR);
        return b;
    endfunction

    // Call at a falling edge; returns at the falling edge after acceptance.
    task automatic push_word(input logic op, input logic [7:0] b, input logic typed,
                             input int n_typed);
        int          gap;
        int          k;
        synth_word_t w;
        gap = pause_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        decode_rx_word(op, b);
        if (typed) begin
            for (k = 0; k < n_typed; k++) begin
                w = typed_words.pop_front();
                w.last = (k == n_typed - 1);
                due_words.push_back(w);
            end
        end else begin
            for (k = 0; k < step_words.size(); k++) due_words.push_back(step_words[k]);
        end
        sent_items++;
        @(negedge aclk);
    endtask

    task automatic line_byte(input logic [7:0] b);
        if ($urandom_range(0, 19) == 0) push_word(OP_TICK, 8'($urandom), 1'b0, 0);
        push_word(OP_RX, b, 1'b0, 0);
    endtask

    task automatic emit_command();
        int          pick;
        int          k;
        logic [15:0] f;
        logic [7:0]  term;
        if ($urandom_range(0, 9) == 0) calm = !calm;
        term = $urandom_range(0, 1) ? vcsw_pkg::CH_LF : vcsw_pkg::CH_CR;
        pick = $urandom_range(0, 99);
        if (pick >= 84) begin
            k = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 6);
            repeat (k) push_word(OP_TICK, 8'($urandom), 1'b0, 0);
        end else begin
            if (pick < 18) begin
                f = 16'($urandom_range(vcsw_pkg::FREQ_MIN, vcsw_pkg::FREQ_MAX));
                line_byte(vcsw_pkg::CH_F);
                line_byte(f[7:0]);
                line_byte(f[15:8]);
            end else if (pick < 24) begin
                line_byte(vcsw_pkg::CH_F);
                line_byte(8'($urandom));
                line_byte(8'($urandom));
            end else if (pick < 40) begin
                line_byte(vcsw_pkg::CH_C);
                line_byte($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 9)));
                line_byte($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 9)));
            end else if (pick < 55) begin
                line_byte(vcsw_pkg::CH_P);
                line_byte($urandom_range(0, 2) == 0 ? 8'h00 : 8'($urandom_range(1, 255)));
            end else if (pick < 65) begin
                line_byte(vcsw_pkg::CH_S);
            end else if (pick < 70) begin
                line_byte(plain_byte());
                repeat ($urandom_range(0, 3)) line_byte(plain_byte());
            end else if (pick < 74) begin
                // empty line
            end else if (pick < 80) begin
                k = $urandom_range(0, 2);
                line_byte(k == 0 ? vcsw_pkg::CH_F : (k == 1 ? vcsw_pkg::CH_C : vcsw_pkg::CH_P));
                if (k != 2) repeat ($urandom_range(0, 1)) line_byte(plain_byte());
            end else begin
                // long line, around the overflow point
                line_byte(vcsw_pkg::CH_S);
                repeat ($urandom_range(29, 36)) line_byte(plain_byte());
            end
            if (pick < 70 && $urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3)) line_byte(plain_byte());
            line_byte(term);
        end
    endtask

    // Hold the sender until every expected word is back, then let the pipe empty.
    task automatic drain_synth_words();
        int k;
        s_tvalid <= 1'b0;
        for (k = 0; k < 20000 && due_words.size() != 0; k++) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic play_phase(input int quota);
        int stop_at;
        int half;
        stop_at = sent_items;
        for (half = 0; half < 2; half++) begin
            stop_at += (half == 0) ? quota / 2 : quota - quota / 2;
            while (sent_items < stop_at) emit_command();
            drain_synth_words();
        end
    endtask

    task automatic write_reg(input vcsw_pkg::cfg_idx_t idx, input logic [19:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        unique case (idx)
            vcsw_pkg::CFG_SETTLE_TICKS:     reg_settle  = val[15:0];
            vcsw_pkg::CFG_PA_FULL_WORD:     reg_pa_full = val;
            vcsw_pkg::CFG_PA_LOW_WORD:      reg_pa_low  = val;
            vcsw_pkg::CFG_VCO_CONTROL_WORD: reg_vco     = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Result checker
    always @(posedge aclk) begin
        synth_word_t got;
        synth_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind  = m_tuser;
            got.frame = m_tdata[24:0];
            got.reply = m_tdata[32:25];
            got.last  = m_tlast;
            if (due_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: kind %0d frame %h reply %h last %0d",
                             got.kind, got.frame, got.reply, got.last);
            end else begin
                want = due_words.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"word mismatch: expected kind %0d frame %h reply %h last %0d,",
                                  " got kind %0d frame %h reply %h last %0d"},
                                 want.kind, want.frame, want.reply, want.last,
                                 got.kind, got.frame, got.reply, got.last);
                end
            end
        end
    end

    // Receiver: random stall before each word
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = pause_len();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    initial begin
        int          i;
        int          ph;
        logic [19:0] settle;
        logic [19:0] full;
        logic [19:0] low;
        logic [19:0] vco;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tuser   = OP_RX;
        cfg_valid = 1'b0;
        cfg_addr  = vcsw_pkg::CFG_SETTLE_TICKS;
        cfg_data  = 20'h0;

        dir_rows = '{
            '{OP_TICK, 8'h00,           1'b1, 2'd0},   // tick while disarmed
            '{OP_RX,   vcsw_pkg::CH_S,  1'b1, 2'd0},
            '{OP_RX,   vcsw_pkg::CH_LF, 1'b1, 2'd3},
            '{OP_RX,   vcsw_pkg::CH_CR, 1'b1, 2'd0},   // empty line
            '{OP_RX,   vcsw_pkg::CH_P,  1'b1, 2'd0},
            '{OP_RX,   8'h00,           1'b1, 2'd0},
            '{OP_RX,   vcsw_pkg::CH_CR, 1'b1, 2'd2},   // power level zero
            '{OP_RX,   vcsw_pkg::CH_P,  1'b1, 2'd0},
            '{OP_RX,   8'hFF,           1'b1, 2'd0},
            '{OP_RX,   vcsw_pkg::CH_LF, 1'b1, 2'd3},
            '{OP_RX,   vcsw_pkg::CH_F,  1'b1, 2'd0},   // top of band
            '{OP_RX,   8'h39,           1'b1, 2'd0},
            '{OP_RX,   8'h17,           1'b1, 2'd0},
            '{OP_RX,   vcsw_pkg::CH_LF, 1'b0, 2'd0},
            '{OP_RX,   vcsw_pkg::CH_C,  1'b1, 2'd0},   // band and channel out of table
            '{OP_RX,   8'hFF,           1'b1, 2'd0},
            '{OP_RX,   8'hFF,           1'b1, 2'd0},
            '{OP_RX,   vcsw_pkg::CH_CR, 1'b0, 2'd0},
            '{OP_RX,   vcsw_pkg::CH_F,  1'b1, 2'd0},   // frequency out of range
            '{OP_RX,   8'hFF,           1'b1, 2'd0},
            '{OP_RX,   8'hFF,           1'b1, 2'd0},
            '{OP_RX,   vcsw_pkg::CH_LF, 1'b1, 2'd0},
            '{OP_RX,   CH_UNKNOWN,      1'b1, 2'd0},
            '{OP_RX,   vcsw_pkg::CH_LF, 1'b1, 2'd0},
            '{OP_RX,   vcsw_pkg::CH_F,  1'b1, 2'd0},   // short F line
            '{OP_RX,   vcsw_pkg::CH_LF, 1'b1, 2'd0}
        };
        typed_words.push_back(reply_word(vcsw_pkg::CH_F));
        typed_words.push_back(reply_word(8'hB1));
        typed_words.push_back(reply_word(8'h16));
        typed_words.push_back(frame_word(vcsw_pkg::ADDR_PA, 20'h00000));
        typed_words.push_back(frame_word(vcsw_pkg::ADDR_PA, 20'h00F3F));
        typed_words.push_back(frame_word(vcsw_pkg::ADDR_PA, 20'h00000));
        typed_words.push_back(frame_word(vcsw_pkg::ADDR_PA, 20'h00000));
        typed_words.push_back(frame_word(vcsw_pkg::ADDR_PA, 20'h04FBD));

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < 26; i++)
            push_word(dir_rows[i].op, dir_rows[i].b, dir_rows[i].typed, int'(dir_rows[i].n));
        play_phase(54);

        for (ph = 1; ph <= 5; ph++) begin
            full = 20'($urandom);
            low  = 20'($urandom);
            vco  = 20'($urandom);
            unique case (ph)
                1: begin
                    settle = 20'h00000;
                    full = 20'h00000;
                    low  = 20'h00000;
                    vco  = 20'h00000;
                end
                2: begin
                    settle = 20'hFFFFF;
                    full = 20'hFFFFF;
                    low  = 20'hFFFFF;
                    vco  = 20'hFFFFF;
                end
                3: settle = {4'($urandom), 16'($urandom_range(1, 4))};
                4: settle = {4'($urandom), 16'($urandom_range(0, 12))};
                default: settle = {4'($urandom), 16'd2};
            endcase
            write_reg(vcsw_pkg::CFG_VCO_CONTROL_WORD, vco);
            write_reg(vcsw_pkg::CFG_SETTLE_TICKS, settle);
            write_reg(vcsw_pkg::CFG_PA_LOW_WORD, low);
            write_reg(vcsw_pkg::CFG_PA_FULL_WORD, full);
            play_phase(66);
        end

        mismatches += due_words.size();
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
